>>> sv/eegsd_pkg.sv
// Shared types and constants of the EEG data-record sample decoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package eegsd_pkg;

    localparam int EEGSD_MAX_CHANNELS = 256;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 4'd2;

    localparam logic [8:0]  CHANNELS_RESET = 9'd2;
    localparam logic [15:0] SAMPLES_RESET  = 16'd1;
    localparam logic [31:0] GAIN_RESET     = 32'h0100_0000;

    // Effective configuration after clamping
    typedef struct packed {
        logic [7:0]  last_ch;   // index of the status channel
        logic [15:0] spr;       // samples per record, never zero
        logic [31:0] gain;
    } cfg_t;

    // One assembled sample on its way to the scaler
    typedef struct packed {
        logic [7:0]  channel;
        logic [31:0] sample_index;
        logic [23:0] raw;
        logic        is_status;
        logic        trigger;
        logic [15:0] trigger_code;
    } sample_t;

endpackage

>>> sv/eegsd_if.sv
// Handshake interfaces of the decoder: byte input, sample output, config write.
// Depends on eegsd_pkg for the configuration widths.
`timescale 1ns / 1ps

interface eegsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface eegsd_sample_if;
    logic               valid;
    logic               ready;
    logic [7:0]         channel;
    logic [31:0]        sample_index;
    logic signed [55:0] scaled_value;
    logic               is_status;
    logic               trigger;
    logic [15:0]        trigger_code;

    modport source (output valid, output channel, output sample_index, output scaled_value,
                    output is_status, output trigger, output trigger_code, input ready);
    modport sink   (input valid, input channel, input sample_index, input scaled_value,
                    input is_status, input trigger, input trigger_code, output ready);
endinterface

interface eegsd_cfg_if
    import eegsd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/eeg_record_sample_demux_core.sv
// Top level of the EEG data-record sample decoder.
// Depends on eegsd_pkg, eegsd_if, eegsd_cfg_regs, eegsd_assembler, eegsd_scaler.
//
// Usage:
//   bytes   - data-record stream after the header, one byte per transaction.
//   samples - one transaction per completed 3-byte little-endian sample:
//             channel, sample index, gain-scaled value (24 fraction bits),
//             and for the status channel the trigger code and trigger flag.
//   cfg     - register writes (channels per record, samples per record, gain);
//             always ready, write only while the block is idle.
// Throughput: one byte per cycle sustained while samples is ready; the rate
//   is set by the single byte input port.
// Path: after the transaction that carries its third byte, a sample passes
//   the assembly register, then the multiply/output register, to samples.
// Reset: registers return to two channels, one sample per record, unity
//   gain; byte phase, channel, sample counters and trigger history clear.
// Stall: a result waiting on samples holds; one more sample is held in the
//   assembly register, and bytes.ready drops only when both are full.
`timescale 1ns / 1ps

module eeg_record_sample_demux_core
    import eegsd_pkg::*;
#(
    parameter int MAX_CHANNELS = EEGSD_MAX_CHANNELS
) (
    input  logic           clk,
    input  logic           rst_n,
    eegsd_byte_if.sink     bytes,
    eegsd_sample_if.source samples,
    eegsd_cfg_if.sink      cfg
);

    cfg_t    cfg_eff;
    logic    s1_valid;
    logic    s1_ready;
    sample_t s1_sample;

    eegsd_cfg_regs #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_eff (cfg_eff)
    );

    eegsd_assembler #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .cfg_eff   (cfg_eff),
        .s1_valid  (s1_valid),
        .s1_sample (s1_sample),
        .s1_ready  (s1_ready)
    );

    eegsd_scaler u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (cfg_eff.gain),
        .s1_valid  (s1_valid),
        .s1_sample (s1_sample),
        .s1_ready  (s1_ready),
        .samples   (samples)
    );

endmodule

>>> sv/eegsd_cfg_regs.sv
// Configuration registers with clamping of channel and sample counts.
// Depends on eegsd_pkg and eegsd_if.
`timescale 1ns / 1ps

module eegsd_cfg_regs
    import eegsd_pkg::*;
#(
    parameter int MAX_CHANNELS = EEGSD_MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    eegsd_cfg_if.sink   cfg,
    output cfg_t        cfg_eff
);

    logic [8:0]  channels_reg;
    logic [15:0] samples_reg;
    logic [31:0] gain_reg;
    logic [8:0]  ch_clamped;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= CHANNELS_RESET;
            samples_reg  <= SAMPLES_RESET;
            gain_reg     <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CHANNELS: channels_reg <= cfg.data[8:0];
                REG_SAMPLES:  samples_reg  <= cfg.data[15:0];
                REG_GAIN:     gain_reg     <= cfg.data[31:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (channels_reg < 9'd2)
            ch_clamped = 9'd2;
        else if (channels_reg > 9'(MAX_CHANNELS))
            ch_clamped = 9'(MAX_CHANNELS);
        else
            ch_clamped = channels_reg;
    end

    assign cfg_eff.last_ch = 8'(ch_clamped - 9'd1);
    assign cfg_eff.spr     = (samples_reg == 16'd0) ? 16'd1 : samples_reg;
    assign cfg_eff.gain    = gain_reg;

endmodule

>>> sv/eegsd_assembler.sv
// Byte-to-sample assembly, channel/sample bookkeeping and trigger detection.
// Depends on eegsd_pkg and eegsd_if; feeds eegsd_scaler through a register.
`timescale 1ns / 1ps

module eegsd_assembler
    import eegsd_pkg::*;
#(
    parameter int MAX_CHANNELS = EEGSD_MAX_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    eegsd_byte_if.sink  bytes,
    input  cfg_t        cfg_eff,
    output logic        s1_valid,
    output sample_t     s1_sample,
    input  logic        s1_ready
);

    localparam int CH_W = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_MID,
        PH_HIGH
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [15:0]     partial_reg, partial_next;
    logic [CH_W-1:0] chan_reg, chan_next;
    logic [15:0]     sir_reg, sir_next;
    logic [31:0]     base_reg, base_next;
    logic [15:0]     prev_code_reg, prev_code_next;
    logic            seen_reg, seen_next;
    logic            s1_valid_reg, s1_valid_next;
    sample_t         s1_reg, s1_next;

    logic        accept;
    logic [23:0] raw;
    logic [15:0] code;
    logic        status;
    logic        trig;
    logic [15:0] sir_inc;
    logic        rec_wrap;

    assign bytes.ready = !s1_valid_reg || s1_ready;
    assign accept      = bytes.valid && bytes.ready;

    assign raw     = {bytes.data_byte, partial_reg};
    assign code    = raw[15:0];
    assign status  = 8'(chan_reg) >= cfg_eff.last_ch;
    assign sir_inc = sir_reg + 16'd1;
    assign rec_wrap = (sir_inc >= cfg_eff.spr) || (sir_inc == 16'd0);

    // First status sample: any nonzero code; afterwards a rise in either byte
    always_comb
    begin
        if (!seen_reg)
            trig = code != 16'd0;
        else
            trig = (code != 16'd0) &&
                   ((code[7:0] > prev_code_reg[7:0]) || (code[15:8] > prev_code_reg[15:8]));
    end

    always_comb
    begin
        phase_next     = phase_reg;
        partial_next   = partial_reg;
        chan_next      = chan_reg;
        sir_next       = sir_reg;
        base_next      = base_reg;
        prev_code_next = prev_code_reg;
        seen_next      = seen_reg;
        s1_valid_next  = s1_valid_reg && !s1_ready;
        s1_next        = s1_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    partial_next = {8'd0, bytes.data_byte};
                    phase_next   = PH_MID;
                end
                PH_MID:
                begin
                    partial_next[15:8] = bytes.data_byte;
                    phase_next         = PH_HIGH;
                end
                default:
                begin
                    phase_next = PH_LOW;

                    s1_valid_next          = 1'b1;
                    s1_next.channel        = 8'(chan_reg);
                    s1_next.sample_index   = base_reg + 32'(sir_reg);
                    s1_next.raw            = raw;
                    s1_next.is_status      = status;
                    s1_next.trigger        = status && trig;
                    s1_next.trigger_code   = status ? code : 16'd0;

                    if (status)
                    begin
                        prev_code_next = code;
                        seen_next      = 1'b1;
                    end

                    if (rec_wrap)
                    begin
                        sir_next = 16'd0;
                        if (status)
                        begin
                            chan_next = '0;
                            base_next = base_reg + 32'(cfg_eff.spr);
                        end
                        else
                            chan_next = chan_reg + CH_W'(1);
                    end
                    else
                        sir_next = sir_inc;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LOW;
            partial_reg   <= '0;
            chan_reg      <= '0;
            sir_reg       <= '0;
            base_reg      <= '0;
            prev_code_reg <= '0;
            seen_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            partial_reg   <= partial_next;
            chan_reg      <= chan_next;
            sir_reg       <= sir_next;
            base_reg      <= base_next;
            prev_code_reg <= prev_code_next;
            seen_reg      <= seen_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_sample = s1_reg;

`ifndef SYNTHESIS
    // a held sample must not be overwritten while the scaler is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("stage 1 sample changed while stalled");

    a_trig_status: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.trigger |-> s1_reg.is_status && s1_reg.trigger_code != 16'd0)
        else $error("trigger on data sample or zero code");

    // a sample leaves the assembler only on the third byte of a triplet
    a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg != PH_HIGH && !(s1_valid_reg && !s1_ready) |=> !s1_valid_reg)
        else $error("sample produced before third byte");
`endif

endmodule

>>> sv/eegsd_scaler.sv
// Gain multiply and output register of the decoder.
// Depends on eegsd_pkg and eegsd_if.
`timescale 1ns / 1ps

module eegsd_scaler
    import eegsd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    gain,
    input  logic           s1_valid,
    input  sample_t        s1_sample,
    output logic           s1_ready,
    eegsd_sample_if.source samples
);

    logic               out_valid_reg, out_valid_next;
    sample_t            out_reg;
    logic signed [55:0] scaled_reg;
    logic signed [56:0] product;
    logic               load;

    assign s1_ready = !out_valid_reg || samples.ready;
    assign load     = s1_valid && s1_ready;

    // 24-bit signed sample times 32-bit unsigned gain
    assign product = $signed(s1_sample.raw) * $signed({1'b0, gain});

    assign out_valid_next = load || (out_valid_reg && !samples.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg    <= s1_sample;
            scaled_reg <= s1_sample.is_status ? 56'sd0 : product[55:0];
        end
    end

    assign samples.valid        = out_valid_reg;
    assign samples.channel      = out_reg.channel;
    assign samples.sample_index = out_reg.sample_index;
    assign samples.scaled_value = scaled_reg;
    assign samples.is_status    = out_reg.is_status;
    assign samples.trigger      = out_reg.trigger;
    assign samples.trigger_code = out_reg.trigger_code;

`ifndef SYNTHESIS
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_status |-> scaled_reg == 56'sd0)
        else $error("status sample carries a scaled value");
`endif

endmodule
